// ----- hw/rtl/mtfs_pkg.sv -----
`default_nettype none

package mtfs_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SLOT_W = 8;

    localparam logic [SLOT_W-1:0] EMPTY_MARK = 8'hFF;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] entry_id;
        logic [6:0] read_slot;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] slot_value;
        logic              was_present;
        logic [6:0]        old_position;
        logic signed [7:0] dropped_entry;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic clr_start;
        logic clr_step;
        logic push_start;
        logic push_step;
        logic read_issue;
        logic read_capture;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_slot;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/move_to_front_stack.sv -----
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_item : op, entry_id, read_slot
// m_       out        m_valid / m_ready  m_item : slot_value, was_present,
//                                                 old_position, dropped_entry
//
// One transaction is worked on at a time; the stack lives in a single-port-write,
// registered-read RAM and a push walks it one slot per cycle.
// A push stops at the slot where the identifier is found, or after the last slot
// when it is absent; a clear writes the empty marker into every slot. A read
// issues one RAM read and captures it; an unused op goes straight to the result.
// After reset the RAM is filled with the empty marker, with s_ready low. A stalled
// result does not hold off input: the next transaction is worked on and then
// waits until the output register is free.
module move_to_front_stack (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mtfs_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mtfs_pkg::out_item_t      m_item
);

    import mtfs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mtfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_item.op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mtfs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Only one transaction is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // The clearing pass blocks input right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during clearing pass");

    // A present identifier never drops an entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.was_present && m_item.dropped_entry != -8'sd1))
        else $error("dropped entry reported on a hit");

    // Old position is only reported for a hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.was_present || m_item.old_position == 7'd0))
        else $error("old position without a hit");

endmodule

`default_nettype wire

// ----- hw/rtl/mtfs_ram.sv -----
`default_nettype none

module mtfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mtfs_datapath.sv -----
`default_nettype none

module mtfs_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mtfs_pkg::in_item_t   s_item,
    input  wire mtfs_pkg::dp_cmd_t    cmd,
    output mtfs_pkg::dp_status_t      status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mtfs_pkg::out_item_t       m_item
);

    import mtfs_pkg::*;

    in_item_t          item_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [SLOT_W-1:0] carry_reg;
    out_item_t         res_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [SLOT_W-1:0] rd_data;
    logic              in_range;

    assign idx_next = idx_reg + 1'b1;
    assign in_range = 32'(item_reg.read_slot) < 32'(STACK_DEPTH);

    // The push walks the stack from the top, writing the carried entry into
    // each slot and picking up the old one; the read of the next slot is
    // issued in the same cycle.
    assign wr_en   = cmd.clr_step | cmd.push_step;
    assign wr_addr = idx_reg;
    assign wr_data = cmd.clr_step ? EMPTY_MARK : carry_reg;
    assign rd_en   = cmd.push_start | cmd.push_step | cmd.read_issue;

    always_comb begin
        if (cmd.read_issue) begin
            rd_addr = ADDR_W'(item_reg.read_slot);
        end else if (cmd.push_start) begin
            rd_addr = '0;
        end else begin
            rd_addr = idx_next;
        end
    end

    mtfs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status.last_slot = (idx_reg == ADDR_W'(STACK_DEPTH - 1));
    assign status.hit       = (rd_data == {1'b0, item_reg.entry_id});
    assign status.out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.clr_start || cmd.push_start) begin
            idx_reg <= '0;
        end else if (cmd.clr_step || cmd.push_step) begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
            res_reg  <= '{slot_value: $signed(EMPTY_MARK), was_present: 1'b0,
                          old_position: 7'd0, dropped_entry: $signed(EMPTY_MARK)};
        end
        if (cmd.push_start) begin
            carry_reg <= {1'b0, item_reg.entry_id};
        end
        if (cmd.push_step) begin
            carry_reg <= rd_data;
            if (status.hit) begin
                res_reg.was_present  <= 1'b1;
                res_reg.old_position <= 7'(idx_reg);
            end else if (status.last_slot) begin
                res_reg.dropped_entry <= $signed(rd_data);
            end
        end
        if (cmd.read_capture) begin
            res_reg.slot_value <= in_range ? $signed(rd_data) : $signed(EMPTY_MARK);
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mtfs_ctrl.sv -----
`default_nettype none

module mtfs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic [1:0]           s_op,
    output logic                      s_ready,
    input  wire mtfs_pkg::dp_status_t status,
    output mtfs_pkg::dp_cmd_t         cmd
);

    import mtfs_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_PSTART = 7'b0000100,
        S_PSTEP  = 7'b0001000,
        S_RISSUE = 7'b0010000,
        S_RCAP   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   reply_reg;
    logic   reply_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        reply_next = reply_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.last_slot) begin
                    // The pass after reset returns no result; a clear op does.
                    state_next = reply_reg ? S_DONE : S_IDLE;
                    reply_next = 1'b0;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    case (s_op)
                        OP_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            reply_next    = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_PUSH: state_next = S_PSTART;
                        OP_READ: state_next = S_RISSUE;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PSTART: begin
                cmd.push_start = 1'b1;
                state_next     = S_PSTEP;
            end
            S_PSTEP: begin
                cmd.push_step = 1'b1;
                if (status.hit || status.last_slot) begin
                    state_next = S_DONE;
                end
            end
            S_RISSUE: begin
                cmd.read_issue = 1'b1;
                state_next     = S_RCAP;
            end
            S_RCAP: begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

endmodule

`default_nettype wire
